### src/nst_pkg.sv
// ============================================================================
// nst_pkg: shared types, constants and functions of the normal shaded texel pixel
// Holds the word sideband that rides along the pipeline. It also holds the
// square root accumulator and the function for one root digit.
// ============================================================================
`default_nettype none

package nst_pkg;

    // Squared unit length of a Q15 normal.
    localparam logic [30:0] UNIT_SQ = 31'h4000_0000;
    localparam logic [7:0]  LEVEL_MAX = 8'd255;
    localparam int unsigned ROOT_W = 16;
    localparam int unsigned REM_W = 32;
    localparam int unsigned SQRT_STAGES = 4;
    localparam int unsigned STEPS_PER_STAGE = ROOT_W / SQRT_STAGES;
    localparam int unsigned FRAC_BITS = 15;

    // Fields that are not used until the end of the pipeline.
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        texel_value;
        logic [7:0]         ramp_index;
        logic               draw;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_acc_t;

    // One digit of the integer square root, for root bit k. The root only
    // holds bits above k, so (root + 2^k)^2 - root^2 = root*2^(k+1) + 2^(2k).
    function automatic sqrt_acc_t sqrt_step(input sqrt_acc_t acc, input int unsigned k);
        sqrt_acc_t        res;
        logic [REM_W-1:0] trial;
        res = acc;
        trial = (REM_W'(acc.root) << (k + 1)) + (REM_W'(1) << (2 * k));
        if (acc.rem >= trial)
        begin
            res.rem = acc.rem - trial;
            res.root = acc.root | (ROOT_W'(1) << k);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### src/nst_square.sv
// ============================================================================
// nst_square: squared z component of the normal
// First stage squares both normals, second stage forms 2^30 - nx^2 - ny^2
// and clamps it at zero.
// ============================================================================
`default_nettype none

module nst_square (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] normal_x,
    input  wire logic signed [15:0] normal_y,
    input  wire nst_pkg::side_t     in_side,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output nst_pkg::sqrt_acc_t      out_acc,
    output nst_pkg::side_t          out_side
);
    import nst_pkg::*;

    logic               sq_valid_reg;
    logic [30:0]        sqx_reg;
    logic [30:0]        sqy_reg;
    side_t              sq_side_reg;
    logic signed [31:0] sqx_next;
    logic signed [31:0] sqy_next;
    logic               sq_ready;

    logic               z_valid_reg;
    sqrt_acc_t          z_acc_reg;
    side_t              z_side_reg;
    sqrt_acc_t          z_acc_next;
    logic [31:0]        sum;
    logic               z_ready;

    assign z_ready  = !z_valid_reg || out_ready;
    assign sq_ready = !sq_valid_reg || z_ready;
    assign in_ready = sq_ready;

    assign sqx_next = normal_x * normal_x;
    assign sqy_next = normal_y * normal_y;

    always_comb
    begin
        sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        z_acc_next.root = '0;
        if (sum > {1'b0, UNIT_SQ})
        begin
            z_acc_next.rem = '0;
        end
        else
        begin
            z_acc_next.rem = {1'b0, UNIT_SQ} - sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            z_valid_reg  <= 1'b0;
        end
        else
        begin
            if (sq_ready)
            begin
                sq_valid_reg <= in_valid;
            end
            if (z_ready)
            begin
                z_valid_reg <= sq_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_ready)
        begin
            sqx_reg     <= 31'(sqx_next);
            sqy_reg     <= 31'(sqy_next);
            sq_side_reg <= in_side;
        end
        if (z_ready)
        begin
            z_acc_reg  <= z_acc_next;
            z_side_reg <= sq_side_reg;
        end
    end

    assign out_valid = z_valid_reg;
    assign out_acc   = z_acc_reg;
    assign out_side  = z_side_reg;

    // The clamped square never exceeds the unit square.
    a_zsq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        z_valid_reg |-> (z_acc_reg.rem <= {1'b0, UNIT_SQ}))
        else $error("z squared above unit square");

endmodule

`default_nettype wire

### src/nst_sqrt.sv
// ============================================================================
// nst_sqrt: pipelined integer square root
// Four register stages, each settling four root bits from the top down.
// ============================================================================
`default_nettype none

module nst_sqrt (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire nst_pkg::sqrt_acc_t in_acc,
    input  wire nst_pkg::side_t     in_side,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [15:0]             out_root,
    output nst_pkg::side_t          out_side
);
    import nst_pkg::*;

    logic [SQRT_STAGES:0] stage_valid;
    logic [SQRT_STAGES:0] stage_ready;
    sqrt_acc_t            stage_acc  [SQRT_STAGES+1];
    side_t                stage_side [SQRT_STAGES+1];

    assign stage_valid[0]           = in_valid;
    assign stage_acc[0]             = in_acc;
    assign stage_side[0]            = in_side;
    assign in_ready                 = stage_ready[0];
    assign stage_ready[SQRT_STAGES] = out_ready;

    for (genvar j = 0; j < SQRT_STAGES; j++)
    begin : g_stage
        logic      valid_reg;
        sqrt_acc_t acc_reg;
        side_t     side_reg;
        sqrt_acc_t acc_next;

        assign stage_ready[j] = !valid_reg || stage_ready[j+1];

        always_comb
        begin
            acc_next = stage_acc[j];
            for (int unsigned i = 0; i < STEPS_PER_STAGE; i++)
            begin
                acc_next = sqrt_step(acc_next, ROOT_W - 1 - j * STEPS_PER_STAGE - i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (stage_ready[j])
            begin
                valid_reg <= stage_valid[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[j])
            begin
                acc_reg  <= acc_next;
                side_reg <= stage_side[j];
            end
        end

        assign stage_valid[j+1] = valid_reg;
        assign stage_acc[j+1]   = acc_reg;
        assign stage_side[j+1]  = side_reg;
    end

    assign out_valid = stage_valid[SQRT_STAGES];
    assign out_root  = stage_acc[SQRT_STAGES].root;
    assign out_side  = stage_side[SQRT_STAGES];

    // The root of at most 2^30 is at most 2^15.
    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[SQRT_STAGES] |-> (stage_acc[SQRT_STAGES].root <= 16'h8000))
        else $error("square root above unit");

    // A floor root leaves a remainder of at most twice the root.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[SQRT_STAGES]
            |-> (stage_acc[SQRT_STAGES].rem <= {15'd0, stage_acc[SQRT_STAGES].root, 1'b0}))
        else $error("square root remainder too large");

endmodule

`default_nettype wire

### src/nst_scale.sv
// ============================================================================
// nst_scale: brightness scaling and saturation
// Multiplies the texel value by the Q15 z length, then shifts and saturates
// the level in the output register.
// ============================================================================
`default_nettype none

module nst_scale (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [15:0]    in_root,
    input  wire nst_pkg::side_t in_side,
    output logic                out_valid,
    input  wire logic           out_ready,
    output nst_pkg::side_t      out_side,
    output logic [7:0]          out_level
);
    import nst_pkg::*;

    logic        mul_valid_reg;
    logic [31:0] prod_reg;
    side_t       mul_side_reg;
    logic        mul_ready;

    logic        res_valid_reg;
    logic [7:0]  level_reg;
    side_t       res_side_reg;
    logic [7:0]  level_next;
    logic [16:0] shifted;
    logic        res_ready;

    assign res_ready = !res_valid_reg || out_ready;
    assign mul_ready = !mul_valid_reg || res_ready;
    assign in_ready  = mul_ready;

    always_comb
    begin
        shifted = 17'(prod_reg >> FRAC_BITS);
        if (shifted > 17'(LEVEL_MAX))
        begin
            level_next = LEVEL_MAX;
        end
        else
        begin
            level_next = shifted[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_ready)
            begin
                mul_valid_reg <= in_valid;
            end
            if (res_ready)
            begin
                res_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_ready)
        begin
            prod_reg     <= in_side.texel_value * in_root;
            mul_side_reg <= in_side;
        end
        if (res_ready)
        begin
            level_reg    <= level_next;
            res_side_reg <= mul_side_reg;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_side  = res_side_reg;
    assign out_level = level_reg;

endmodule

`default_nettype wire

### src/normal_shaded_texel_pixel.sv
// ============================================================================
// normal_shaded_texel_pixel: shades a texel by its surface normal
// Top level of the texel shading pipeline with stream input and output.
// ============================================================================
// Usage:
// Each input word carries one texel: its screen position, its Q15 normal x and
// y, its brightness, its color ramp and its transparency. Each input word gives
// exactly one output word, in order. The output word carries the position, the
// ramp and the shaded level. tuser carries the draw flag, which is set when the
// transparency is zero. The shaded level is the brightness times
// floor(sqrt(2^30 - nx^2 - ny^2)) / 2^15, saturated at 255.
// An accepted word is registered in every stage in turn before it shows as output valid.
// The eight register stages are two for the squares and the z term, four for the root,
// and two for scaling and saturation. One word is taken each cycle unless a stalled
// receiver has filled the pipeline. The root stages settle four bits each, and every
// stage holds one register.
// Every stage has its own valid bit and its own ready. A stalled receiver
// fills the empty stages first. The input side drops tready only once all
// eight stages hold a word, and no word is lost or repeated.
// Reset clears every valid bit, so the pipeline comes up empty with tready high.
// ============================================================================
`default_nettype none

module normal_shaded_texel_pixel (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // pos_x[15:0], pos_y[31:16], normal_x[47:32], normal_y[63:48],
    // texel_value[79:64], ramp_index[87:80], transparency[95:88]
    input  wire logic [95:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_x[15:0], out_y[31:16], out_ramp[39:32], shade_level[47:40]
    output logic [47:0]      m_axis_tdata,
    // draw_enable[0]
    output logic [0:0]       m_axis_tuser
);
    import nst_pkg::*;

    side_t      in_side;
    logic       sq_valid;
    logic       sq_ready;
    sqrt_acc_t  sq_acc;
    side_t      sq_side;
    logic       rt_valid;
    logic       rt_ready;
    logic [15:0] rt_root;
    side_t      rt_side;
    side_t      res_side;
    logic [7:0] res_level;

    // The draw flag is settled at entry so the transparency byte is not carried.
    always_comb
    begin
        in_side.pos_x       = s_axis_tdata[15:0];
        in_side.pos_y       = s_axis_tdata[31:16];
        in_side.texel_value = s_axis_tdata[79:64];
        in_side.ramp_index  = s_axis_tdata[87:80];
        in_side.draw        = (s_axis_tdata[95:88] == 8'd0);
    end

    nst_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .normal_x  (s_axis_tdata[47:32]),
        .normal_y  (s_axis_tdata[63:48]),
        .in_side   (in_side),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_acc   (sq_acc),
        .out_side  (sq_side)
    );

    nst_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_acc    (sq_acc),
        .in_side   (sq_side),
        .out_valid (rt_valid),
        .out_ready (rt_ready),
        .out_root  (rt_root),
        .out_side  (rt_side)
    );

    nst_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .in_ready  (rt_ready),
        .in_root   (rt_root),
        .in_side   (rt_side),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_side  (res_side),
        .out_level (res_level)
    );

    assign m_axis_tdata = {res_level, res_side.ramp_index, res_side.pos_y, res_side.pos_x};
    assign m_axis_tuser = res_side.draw;

    // The input side only stalls when a full pipeline meets a stalled receiver.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

### tb/sv/tb_normal_shaded_texel_pixel.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_normal_shaded_texel_pixel: self-checking bench for the texel shader
// Streams texels into the shader and checks every output pixel against a
// behavioral predictor of the shading math. A short directed set of corner
// texels comes first, then random texels under several idling patterns.
// ============================================================================
`default_nettype none

module tb_normal_shaded_texel_pixel;

    // Shading constants: squared unit length of a Q15 normal and the level ceiling.
    localparam longint UNIT_LEN_SQ = 64'd1073741824;
    localparam int     SHADE_MAX = 255;
    localparam int     FRAC_SHIFT = 15;
    // Pipeline depth given for the block, padded for the final drain.
    localparam int     DRAIN_CYCLES = 24;
    // Cycles with work outstanding but no word moving on either side.
    localparam int     STALL_LIMIT = 2000;
    localparam int     MAX_REPORTS = 10;
    localparam int     ITEMS_PER_PHASE = 250;

    // Input word layout, highest field first, so it packs straight onto tdata.
    typedef struct packed {
        logic [7:0]         transparency;
        logic [7:0]         ramp_index;
        logic [15:0]        texel_value;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_x;
    } texel_t;

    // Output pixel: draw flag from tuser on top of the 48-bit tdata word.
    typedef struct packed {
        logic               draw_enable;
        logic [7:0]         shade_level;
        logic [7:0]         out_ramp;
        logic signed [15:0] out_y;
        logic signed [15:0] out_x;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        src_valid = 1'b0;
    wire logic   src_ready;
    texel_t      src_word = '0;
    wire logic   pix_valid;
    logic        pix_ready = 1'b0;
    wire logic [47:0] pix_data;
    wire logic [0:0]  pix_user;

    // Texels waiting to be driven, and pixels the shader still owes us.
    texel_t texel_backlog[$];
    pixel_t pixel_fifo[$];

    // Idle percentages for the current phase, changed by the stimulus block.
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;

    // Handshake bookkeeping: the monitor counts accepted input words, and the
    // driver counts words it has put on the bus, so it knows when to advance.
    int unsigned texels_taken = 0;
    int unsigned texels_offered = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    normal_shaded_texel_pixel uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (src_valid),
        .s_axis_tready (src_ready),
        .s_axis_tdata  (src_word),
        .m_axis_tvalid (pix_valid),
        .m_axis_tready (pix_ready),
        .m_axis_tdata  (pix_data),
        .m_axis_tuser  (pix_user)
    );

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Floor of the square root, found by trying each root bit from the top.
    function automatic longint floor_root(input longint v);
        longint r;
        longint cand;
        r = 0;
        for (int b = 16; b >= 0; b--)
        begin
            cand = r | (longint'(1) << b);
            if (cand * cand <= v)
                r = cand;
        end
        return r;
    endfunction

    // Predicted pixel for one texel. The z term is formed in 64 bits so the
    // sum of two full-scale squares cannot wrap, and it clamps at zero when
    // the normal is longer than one.
    function automatic pixel_t shade_texel(input texel_t t);
        pixel_t p;
        longint nx;
        longint ny;
        longint z_sq;
        longint z_len;
        longint level;
        nx = longint'(t.normal_x);
        ny = longint'(t.normal_y);
        z_sq = UNIT_LEN_SQ - nx * nx - ny * ny;
        if (z_sq < 0)
            z_sq = 0;
        z_len = floor_root(z_sq);
        level = (longint'(t.texel_value) * z_len) >>> FRAC_SHIFT;
        if (level > SHADE_MAX)
            level = SHADE_MAX;
        p.out_x = t.pos_x;
        p.out_y = t.pos_y;
        p.out_ramp = t.ramp_index;
        p.shade_level = level[7:0];
        p.draw_enable = (t.transparency == 8'd0);
        return p;
    endfunction

    // Random texel. Most normals are either full range, small, or placed
    // right at the unit circle, where the truncated root is most sensitive.
    function automatic texel_t random_texel();
        texel_t t;
        longint nx;
        longint edge_len;
        int unsigned kind;
        t = texel_t'({$urandom, $urandom, $urandom});
        kind = $urandom_range(9);
        if (kind >= 4 && kind <= 5)
        begin
            nx = longint'(t.normal_x);
            edge_len = floor_root(UNIT_LEN_SQ - nx * nx) + $urandom_range(2) - 1;
            if (edge_len > 32767)
                edge_len = 32767;
            if (edge_len < 0)
                edge_len = 0;
            t.normal_y = $urandom_range(1) ? 16'(edge_len) : 16'(-edge_len);
        end
        else if (kind >= 6 && kind <= 7)
        begin
            t.normal_x = 16'($urandom_range(4095)) - 16'sd2048;
            t.normal_y = 16'($urandom_range(4095)) - 16'sd2048;
        end
        else if (kind == 8)
        begin
            t.normal_x = $urandom_range(1) ? 16'h8000 : 16'h0000;
            t.normal_y = $urandom_range(1) ? 16'h8000 : 16'h0000;
        end
        else if (kind == 9)
        begin
            t.normal_y = 16'h0000;
        end
        // Small brightness values, up to 600, often keep the level below the ceiling.
        if ($urandom_range(1))
            t.texel_value = 16'($urandom_range(600));
        if ($urandom_range(3) == 0)
            t.transparency = 8'd0;
        return t;
    endfunction

    function automatic texel_t make_texel(input logic [15:0] px, input logic [15:0] py,
                                          input logic [15:0] nx, input logic [15:0] ny,
                                          input logic [15:0] value, input logic [7:0] ramp,
                                          input logic [7:0] trans);
        texel_t t;
        t.pos_x = px;
        t.pos_y = py;
        t.normal_x = nx;
        t.normal_y = ny;
        t.texel_value = value;
        t.ramp_index = ramp;
        t.transparency = trans;
        return t;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // Compare one received pixel with the oldest prediction, field by field.
    task automatic check_pixel(input pixel_t got);
        pixel_t want;
        if (pixel_fifo.size() == 0)
        begin
            report_mismatch("unexpected pixel, tdata", 0, longint'(got));
        end
        else
        begin
            want = pixel_fifo.pop_front();
            if (got.out_x !== want.out_x)
                report_mismatch("out_x", want.out_x, got.out_x);
            if (got.out_y !== want.out_y)
                report_mismatch("out_y", want.out_y, got.out_y);
            if (got.out_ramp !== want.out_ramp)
                report_mismatch("out_ramp", want.out_ramp, got.out_ramp);
            if (got.shade_level !== want.shade_level)
                report_mismatch("shade_level", want.shade_level, got.shade_level);
            if (got.draw_enable !== want.draw_enable)
                report_mismatch("draw_enable", want.draw_enable, got.draw_enable);
        end
    endtask

    // Driver: updates on the falling edge. A word stays on the bus until the
    // monitor has seen it accepted; then the next one goes out unless the
    // sender idles this cycle. Valid is assigned once per cycle only.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!src_valid || texels_taken == texels_offered)
            begin
                if (texel_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    src_word <= texel_backlog.pop_front();
                    src_valid <= 1'b1;
                    texels_offered++;
                end
                else
                begin
                    src_valid <= 1'b0;
                end
            end
            pix_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Monitor: samples both handshakes at the rising edge. Accepted texels
    // are turned into predictions; accepted pixels are checked in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && src_ready)
            begin
                pixel_fifo.push_back(shade_texel(src_word));
                texels_taken++;
            end
            if (pix_valid && pix_ready)
                check_pixel(pixel_t'({pix_user, pix_data}));
        end
    end

    // Watchdog: counts cycles with work outstanding and nothing moving.
    always @(posedge clk)
    begin
        if ((src_valid && src_ready) || (pix_valid && pix_ready) ||
            (texel_backlog.size() == 0 && !src_valid && pixel_fifo.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_random(input int unsigned count);
        for (int i = 0; i < count; i++)
            texel_backlog.push_back(random_texel());
    endtask

    // Let the driver empty the backlog before the idling pattern changes.
    task automatic wait_backlog_empty();
        while (texel_backlog.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed corners, with no idling on either side.
        // Zero normal: full root, so any bright texel saturates.
        texel_backlog.push_back(make_texel(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                           16'hFFFF, 8'h00, 8'h00));
        texel_backlog.push_back(make_texel(16'h7FFF, 16'h8000, 16'h0000, 16'h0000,
                                           16'h00FF, 8'hFF, 8'h00));
        texel_backlog.push_back(make_texel(16'h8000, 16'h7FFF, 16'h0000, 16'h0000,
                                           16'h0100, 8'h5A, 8'h01));
        // Brightness zero gives level zero whatever the normal.
        texel_backlog.push_back(make_texel(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                                           16'h0000, 8'hA5, 8'hFF));
        // Both normals at the most negative value: the sum of the squares needs
        // 32 bits, and the z term must clamp to zero.
        texel_backlog.push_back(make_texel(16'h1234, 16'h4321, 16'h8000, 16'h8000,
                                           16'hFFFF, 8'h11, 8'h00));
        // A single axis at full length: z is exactly zero.
        texel_backlog.push_back(make_texel(16'h0001, 16'h0002, 16'h8000, 16'h0000,
                                           16'hFFFF, 8'h22, 8'h00));
        texel_backlog.push_back(make_texel(16'h0003, 16'h0004, 16'h0000, 16'h8000,
                                           16'hFFFF, 8'h33, 8'h80));
        // Just inside the unit circle on one axis.
        texel_backlog.push_back(make_texel(16'h0005, 16'h0006, 16'h7FFF, 16'h0000,
                                           16'hFFFF, 8'h44, 8'h00));
        // Normal longer than one: clamps to zero.
        texel_backlog.push_back(make_texel(16'h0007, 16'h0008, 16'h7FFF, 16'h7FFF,
                                           16'hFFFF, 8'h55, 8'h00));
        texel_backlog.push_back(make_texel(16'h0009, 16'h000A, 16'h6000, 16'hA000,
                                           16'hFFFF, 8'h66, 8'h7F));
        // Forty-five degrees in the normal plane: z is near zero, root 209, so the level is near zero.
        texel_backlog.push_back(make_texel(16'h000B, 16'h000C, 16'h5A82, 16'h5A82,
                                           16'h0100, 8'h77, 8'h00));
        texel_backlog.push_back(make_texel(16'h000D, 16'h000E, 16'hA57E, 16'h5A82,
                                           16'h0168, 8'h88, 8'h00));
        // Small normals with brightness right at the saturation boundary.
        texel_backlog.push_back(make_texel(16'h000F, 16'h0010, 16'h0001, 16'hFFFF,
                                           16'h0100, 8'h99, 8'h00));
        texel_backlog.push_back(make_texel(16'h0011, 16'h0012, 16'hFFFF, 16'h0001,
                                           16'h00FF, 8'hAA, 8'h00));
        texel_backlog.push_back(make_texel(16'h0013, 16'h0014, 16'h0100, 16'h0100,
                                           16'h0001, 8'hBB, 8'h00));
        // Edge of the circle, 3-4-5 triangle: x and y near 0.8 and 0.6 of unit, so z is near zero.
        texel_backlog.push_back(make_texel(16'h0015, 16'h0016, 16'h6666, 16'h4CCD,
                                           16'h0200, 8'hCC, 8'h00));

        queue_random(ITEMS_PER_PHASE);
        wait_backlog_empty();

        src_idle_pct = 52;
        snk_stall_pct = 0;
        queue_random(ITEMS_PER_PHASE);
        wait_backlog_empty();

        src_idle_pct = 0;
        snk_stall_pct = 52;
        queue_random(ITEMS_PER_PHASE);
        wait_backlog_empty();

        src_idle_pct = 36;
        snk_stall_pct = 36;
        queue_random(ITEMS_PER_PHASE);
        wait_backlog_empty();

        // Wait for the last texel to be taken and every pixel to come back.
        while (src_valid && texels_taken != texels_offered)
            @(posedge clk);
        while (pixel_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pixel_fifo.size() != 0)
            report_mismatch("pixels still owed", 0, pixel_fifo.size());
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
